FILE: src/rfb_pkg.sv
// shared widths, constants and types of the rgb fade and bounce engine
package rfb_pkg;

   localparam int BYTE_W      = 8;
   localparam int COLOR_BYTES = 3;
   localparam int COLOR_W     = BYTE_W * COLOR_BYTES;
   localparam int PERIOD_W    = 31;
   localparam int TIME_W      = 32;
   localparam int SCALE_W     = 9;
   localparam int LIMIT_W     = 8;
   localparam int HALF_W      = 9;
   localparam int PCT_W       = 7;
   localparam int DUTY_W      = 8;
   localparam int NUM_OUT_CH  = 3;

   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 31;

   // percent scale, also the multiplier of the elapsed time
   localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

   // reciprocal of 100: floor(x/100) = (x*5243) >> 19 for x up to 25500
   localparam int RECIP_100_W     = 13;
   localparam int RECIP_100_SHIFT = 19;
   localparam logic [RECIP_100_W-1:0] RECIP_100 = 13'd5243;
   localparam int PROD1_W = PCT_W + BYTE_W;
   localparam int PROD2_W = PROD1_W + RECIP_100_W;

   // reciprocal of 255: floor(x/255) = (x*131587) >> 25 for x below 132626
   localparam int RECIP_255_W     = 18;
   localparam int RECIP_255_SHIFT = 25;
   localparam logic [RECIP_255_W-1:0] RECIP_255 = 18'd131587;
   localparam int SCALED_W = BYTE_W + SCALE_W;
   localparam int NORM_W   = SCALED_W + RECIP_255_W;
   localparam int NORM_HI_W = NORM_W - RECIP_255_SHIFT;
   localparam logic [DUTY_W-1:0] DUTY_MAX = 8'hFF;

   localparam logic [PERIOD_W-1:0] PERIOD_RST      = 31'd1000;
   localparam logic [SCALE_W-1:0]  SCALE_RED_RST   = 9'd160;
   localparam logic [SCALE_W-1:0]  SCALE_GREEN_RST = 9'd107;
   localparam logic [SCALE_W-1:0]  SCALE_BLUE_RST  = 9'd256;
   localparam logic [SCALE_W-1:0]  SCALE_UNITY     = 9'd256;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_COLOR  = 3'd0,
      CSR_END_COLOR    = 3'd1,
      CSR_PERIOD_MS    = 3'd2,
      CSR_BOUNCE_MODE  = 3'd3,
      CSR_BOUNCE_LIMIT = 3'd4,
      CSR_SCALE_RED    = 3'd5,
      CSR_SCALE_GREEN  = 3'd6,
      CSR_SCALE_BLUE   = 3'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DIVIDE = 4'b0010,
      ST_BLEND  = 4'b0100,
      ST_DONE   = 4'b1000
   } state_type;

   typedef enum logic [3:0] {
      PH_DIFF   = 4'b0001,
      PH_DIV100 = 4'b0010,
      PH_MIX    = 4'b0100,
      PH_SCALE  = 4'b1000
   } phase_type;

   typedef struct packed {
      logic                start;
      logic [TIME_W-1:0]   elapsed;
      logic [PERIOD_W-1:0] period;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [PCT_W-1:0] pct;
   } div_rsp_type;

endpackage

FILE: src/rfb_channels.sv
// valid/ready channel interfaces for requests, results and register writes
interface rfb_req_if;
   logic                      valid;
   logic                      ready;
   logic                      cmd;
   logic [rfb_pkg::TIME_W-1:0] now_ms;

   modport source (output valid, output cmd, output now_ms, input ready);
   modport sink   (input valid, input cmd, input now_ms, output ready);
endinterface

interface rfb_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [rfb_pkg::DUTY_W-1:0] duty_red;
   logic [rfb_pkg::DUTY_W-1:0] duty_green;
   logic [rfb_pkg::DUTY_W-1:0] duty_blue;
   logic                      period_over;
   logic                      stopped;

   modport source (output valid, output duty_red, output duty_green, output duty_blue,
                   output period_over, output stopped, input ready);
   modport sink   (input valid, input duty_red, input duty_green, input duty_blue,
                   input period_over, input stopped, output ready);
endinterface

interface rfb_csr_if;
   logic                          valid;
   logic                          ready;
   logic [rfb_pkg::CSR_IDX_W-1:0]  index;
   logic [rfb_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/rfb_pct_divider.sv
// bit-serial percent divider: min(100, floor(100*elapsed/period))
module rfb_pct_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  rfb_pkg::div_req_type div_req,
   output rfb_pkg::div_rsp_type div_rsp
);

   localparam int NUM_W = rfb_pkg::PERIOD_W + rfb_pkg::PCT_W;
   localparam int CNT_W = $clog2(rfb_pkg::PCT_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(rfb_pkg::PCT_W - 1);

   logic [rfb_pkg::TIME_W-1:0]   elapsed_ff, elapsed_in;
   logic [rfb_pkg::PERIOD_W-1:0] period_ff, period_in;
   logic [rfb_pkg::PERIOD_W-1:0] rem_ff, rem_in;
   logic [rfb_pkg::PCT_W-1:0]    low_ff, low_in;
   logic [rfb_pkg::PCT_W-1:0]    quot_ff, quot_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic                         load_ff, load_in;
   logic                         run_ff, run_in;
   logic                         done_ff, done_in;

   logic [NUM_W-1:0]             numer;
   logic [rfb_pkg::PERIOD_W:0]   trial;
   logic                         fits;

   // quotient below 128 once elapsed < period, so seven steps suffice
   always_comb begin
      numer = NUM_W'(elapsed_ff[rfb_pkg::PERIOD_W-1:0]) * NUM_W'(rfb_pkg::PCT_FULL);
      trial = {rem_ff, low_ff[rfb_pkg::PCT_W-1]};
      fits  = (trial >= {1'b0, period_ff});

      elapsed_in = elapsed_ff;
      period_in  = period_ff;
      rem_in     = rem_ff;
      low_in     = low_ff;
      quot_in    = quot_ff;
      cnt_in     = cnt_ff;
      load_in    = 1'b0;
      run_in     = run_ff;
      done_in    = 1'b0;

      if (div_req.start) begin
         elapsed_in = div_req.elapsed;
         period_in  = div_req.period;
         load_in    = 1'b1;
      end

      if (load_ff) begin
         if (elapsed_ff >= {1'b0, period_ff}) begin
            quot_in = rfb_pkg::PCT_FULL;
            done_in = 1'b1;
         end else begin
            rem_in = numer[NUM_W-1:rfb_pkg::PCT_W];
            low_in = numer[rfb_pkg::PCT_W-1:0];
            cnt_in = '0;
            run_in = 1'b1;
         end
      end

      if (run_ff) begin
         rem_in  = fits ? rfb_pkg::PERIOD_W'(trial - {1'b0, period_ff})
                        : trial[rfb_pkg::PERIOD_W-1:0];
         quot_in = {quot_ff[rfb_pkg::PCT_W-2:0], fits};
         low_in  = {low_ff[rfb_pkg::PCT_W-2:0], 1'b0};
         cnt_in  = cnt_ff + CNT_W'(1);
         if (cnt_ff == LAST_STEP) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff <= 1'b0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         load_ff <= load_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      elapsed_ff <= elapsed_in;
      period_ff  <= period_in;
      rem_ff     <= rem_in;
      low_ff     <= low_in;
      quot_ff    <= quot_in;
      cnt_ff     <= cnt_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.pct  = quot_ff;

endmodule

FILE: src/rgb_fade_bounce_engine_top.sv
// top level of the rgb fade and bounce engine
//
// usage
// - req_chan carries a request: cmd 1 starts an animation at now_ms, cmd 0 renders at now_ms
// - rsp_chan returns one result per request: three pwm duties, period_over and stopped
// - csr_chan writes the eight registers (colors, period, bounce mode and limit, scales);
//   it is always ready and is meant to be written only while no request is in flight
// - a render request runs through the bit-serial percent divider (seven steps) and then
//   the per-channel blend in its diff, div100, mix and scale steps through one shared
//   multiplier chain; a start request skips the divider and blends at zero percent
// - one request is worked at a time; a new request is taken as soon as the engine is
//   idle, even while the previous result still waits in the output register
// - if the receiver stalls, the finished result waits in the engine until the output
//   register frees, then goes out together with the animation state update
// - reset (synchronous) restores the register reset values, clears both color sets,
//   the bounce state and the begin time, and sets the active period to 1000 ms
module rgb_fade_bounce_engine_top #(
   parameter int NUM_CHANNELS = 3
) (
   input  logic     clock,
   input  logic     reset,
   rfb_req_if.sink  req_chan,
   rfb_rsp_if.source rsp_chan,
   rfb_csr_if.sink  csr_chan
);

   localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

   // configuration registers
   logic [rfb_pkg::COLOR_W-1:0]  start_color_ff, start_color_in;
   logic [rfb_pkg::COLOR_W-1:0]  end_color_ff, end_color_in;
   logic [rfb_pkg::PERIOD_W-1:0] period_ff, period_in;
   logic                         bounce_mode_ff, bounce_mode_in;
   logic [rfb_pkg::LIMIT_W-1:0]  bounce_limit_ff, bounce_limit_in;
   logic [rfb_pkg::SCALE_W-1:0]  scale_red_ff, scale_red_in;
   logic [rfb_pkg::SCALE_W-1:0]  scale_green_ff, scale_green_in;
   logic [rfb_pkg::SCALE_W-1:0]  scale_blue_ff, scale_blue_in;

   // animation state, color sets kept as rings that rotate by one channel per channel blended
   logic [rfb_pkg::BYTE_W-1:0]   from_ff [NUM_CHANNELS];
   logic [rfb_pkg::BYTE_W-1:0]   from_in [NUM_CHANNELS];
   logic [rfb_pkg::BYTE_W-1:0]   to_ff   [NUM_CHANNELS];
   logic [rfb_pkg::BYTE_W-1:0]   to_in   [NUM_CHANNELS];
   logic                         bouncing_ff, bouncing_in;
   logic [rfb_pkg::TIME_W-1:0]   begin_ff, begin_in;
   logic [rfb_pkg::PERIOD_W-1:0] active_period_ff, active_period_in;
   logic [rfb_pkg::HALF_W-1:0]   half_done_ff, half_done_in;
   logic [rfb_pkg::LIMIT_W-1:0]  limit_ff, limit_in;

   // sequencer
   rfb_pkg::state_type           state_ff, state_in;
   rfb_pkg::phase_type           phase_ff, phase_in;
   logic [CH_W-1:0]              ch_ff, ch_in;
   logic                         cmd_ff, cmd_in;
   logic [rfb_pkg::TIME_W-1:0]   now_ff, now_in;
   logic [rfb_pkg::PCT_W-1:0]    pct_ff, pct_in;
   logic                         reached_ff, reached_in;

   // blend datapath
   logic [rfb_pkg::BYTE_W-1:0]   from_hold_ff, from_hold_in;
   logic [rfb_pkg::BYTE_W-1:0]   to_hold_ff, to_hold_in;
   logic                         neg_ff, neg_in;
   logic [rfb_pkg::SCALE_W-1:0]  scale_hold_ff, scale_hold_in;
   logic [rfb_pkg::PROD1_W-1:0]  prod1_ff, prod1_in;
   logic [rfb_pkg::PROD2_W-1:0]  prod2_ff, prod2_in;
   logic [rfb_pkg::SCALED_W-1:0] x_ff, x_in;
   logic [rfb_pkg::DUTY_W-1:0]   duty_ff [rfb_pkg::NUM_OUT_CH];
   logic [rfb_pkg::DUTY_W-1:0]   duty_in [rfb_pkg::NUM_OUT_CH];

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [rfb_pkg::DUTY_W-1:0]   rsp_duty_ff [rfb_pkg::NUM_OUT_CH];
   logic [rfb_pkg::DUTY_W-1:0]   rsp_duty_in [rfb_pkg::NUM_OUT_CH];
   logic                         rsp_over_ff, rsp_over_in;
   logic                         rsp_stop_ff, rsp_stop_in;

   // combinational helpers
   logic [rfb_pkg::BYTE_W-1:0]   start_byte [NUM_CHANNELS];
   logic [rfb_pkg::BYTE_W-1:0]   end_byte   [NUM_CHANNELS];
   logic                         req_accept;
   logic                         rsp_free;
   logic [rfb_pkg::SCALE_W-1:0]  scale_sel;
   logic                         head_neg;
   logic [rfb_pkg::BYTE_W-1:0]   head_mag;
   logic [rfb_pkg::BYTE_W-1:0]   mix_q;
   logic [rfb_pkg::BYTE_W-1:0]   mix_col;
   logic [rfb_pkg::NORM_W-1:0]   norm;
   logic [rfb_pkg::NORM_HI_W-1:0] norm_hi;
   logic [rfb_pkg::DUTY_W-1:0]   duty_val;
   logic                         bounce_hit;
   logic [rfb_pkg::HALF_W-1:0]   half_next;
   logic                         stop_now;
   logic [rfb_pkg::TIME_W-1:0]   begin_next;
   logic [rfb_pkg::TIME_W-1:0]   elapsed_next;
   logic                         over_next;

   rfb_pkg::div_req_type         div_req;
   rfb_pkg::div_rsp_type         div_rsp;

   rfb_pct_divider u_pct_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // channel i takes byte NUM_CHANNELS-1-i of the packed colors, zero past the top byte
   for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_bytes
      localparam int BYTE_POS = NUM_CHANNELS - 1 - i;
      if (BYTE_POS < rfb_pkg::COLOR_BYTES) begin : g_in_range
         assign start_byte[i] = start_color_ff[rfb_pkg::BYTE_W*BYTE_POS +: rfb_pkg::BYTE_W];
         assign end_byte[i]   = end_color_ff[rfb_pkg::BYTE_W*BYTE_POS +: rfb_pkg::BYTE_W];
      end else begin : g_out_range
         assign start_byte[i] = '0;
         assign end_byte[i]   = '0;
      end
   end

   assign req_accept     = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == rfb_pkg::ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   // datapath pieces
   always_comb begin
      // scale of the channel at the head of the ring
      scale_sel = rfb_pkg::SCALE_UNITY;
      if (NUM_CHANNELS > 0 && ch_ff == CH_W'(0)) begin
         scale_sel = scale_red_ff;
      end
      if (NUM_CHANNELS > 1 && ch_ff == CH_W'(1)) begin
         scale_sel = scale_green_ff;
      end
      if (NUM_CHANNELS > 2 && ch_ff == CH_W'(2)) begin
         scale_sel = scale_blue_ff;
      end

      // sign and magnitude of to - from
      head_neg = (to_ff[0] < from_ff[0]);
      head_mag = head_neg ? (from_ff[0] - to_ff[0]) : (to_ff[0] - from_ff[0]);

      // truncation toward zero: divide the magnitude, then apply the sign
      mix_q   = prod2_ff[rfb_pkg::RECIP_100_SHIFT +: rfb_pkg::BYTE_W];
      mix_col = neg_ff ? (from_hold_ff - mix_q) : (from_hold_ff + mix_q);

      // duty = min(255, color*scale/255)
      norm     = rfb_pkg::NORM_W'(x_ff) * rfb_pkg::NORM_W'(rfb_pkg::RECIP_255);
      norm_hi  = norm[rfb_pkg::NORM_W-1:rfb_pkg::RECIP_255_SHIFT];
      duty_val = (norm_hi > rfb_pkg::NORM_HI_W'(rfb_pkg::DUTY_MAX)) ? rfb_pkg::DUTY_MAX
                                                                    : norm_hi[rfb_pkg::DUTY_W-1:0];

      // bounce bookkeeping at the end of a render
      bounce_hit   = bouncing_ff && reached_ff && !cmd_ff;
      half_next    = half_done_ff + rfb_pkg::HALF_W'(1);
      stop_now     = bounce_hit && (limit_ff != '0)
                     && (half_next[rfb_pkg::HALF_W-1:1] == limit_ff);
      begin_next   = !bounce_hit ? begin_ff : (stop_now ? '0 : now_ff);
      elapsed_next = now_ff - begin_next;
      over_next    = (elapsed_next > {1'b0, active_period_ff});
   end

   // next-state logic
   always_comb begin
      start_color_in   = start_color_ff;
      end_color_in     = end_color_ff;
      period_in        = period_ff;
      bounce_mode_in   = bounce_mode_ff;
      bounce_limit_in  = bounce_limit_ff;
      scale_red_in     = scale_red_ff;
      scale_green_in   = scale_green_ff;
      scale_blue_in    = scale_blue_ff;

      for (int i = 0; i < NUM_CHANNELS; i++) begin
         from_in[i] = from_ff[i];
         to_in[i]   = to_ff[i];
      end
      bouncing_in      = bouncing_ff;
      begin_in         = begin_ff;
      active_period_in = active_period_ff;
      half_done_in     = half_done_ff;
      limit_in         = limit_ff;

      state_in   = state_ff;
      phase_in   = phase_ff;
      ch_in      = ch_ff;
      cmd_in     = cmd_ff;
      now_in     = now_ff;
      pct_in     = pct_ff;
      reached_in = reached_ff;

      from_hold_in  = from_hold_ff;
      to_hold_in    = to_hold_ff;
      neg_in        = neg_ff;
      scale_hold_in = scale_hold_ff;
      prod1_in      = prod1_ff;
      prod2_in      = prod2_ff;
      x_in          = x_ff;
      for (int k = 0; k < rfb_pkg::NUM_OUT_CH; k++) begin
         duty_in[k]     = duty_ff[k];
         rsp_duty_in[k] = rsp_duty_ff[k];
      end

      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_over_in  = rsp_over_ff;
      rsp_stop_in  = rsp_stop_ff;

      div_req = '0;

      // register writes
      if (csr_chan.valid) begin
         case (rfb_pkg::csr_index_type'(csr_chan.index))
            rfb_pkg::CSR_START_COLOR: begin
               start_color_in = csr_chan.data[rfb_pkg::COLOR_W-1:0];
            end
            rfb_pkg::CSR_END_COLOR: begin
               end_color_in = csr_chan.data[rfb_pkg::COLOR_W-1:0];
            end
            rfb_pkg::CSR_PERIOD_MS: begin
               period_in = csr_chan.data[rfb_pkg::PERIOD_W-1:0];
            end
            rfb_pkg::CSR_BOUNCE_MODE: begin
               bounce_mode_in = csr_chan.data[0];
            end
            rfb_pkg::CSR_BOUNCE_LIMIT: begin
               bounce_limit_in = csr_chan.data[rfb_pkg::LIMIT_W-1:0];
            end
            rfb_pkg::CSR_SCALE_RED: begin
               scale_red_in = csr_chan.data[rfb_pkg::SCALE_W-1:0];
            end
            rfb_pkg::CSR_SCALE_GREEN: begin
               scale_green_in = csr_chan.data[rfb_pkg::SCALE_W-1:0];
            end
            rfb_pkg::CSR_SCALE_BLUE: begin
               scale_blue_in = csr_chan.data[rfb_pkg::SCALE_W-1:0];
            end
            default: begin
               start_color_in = start_color_ff;
            end
         endcase
      end

      case (state_ff)
         rfb_pkg::ST_IDLE: begin
            if (req_accept) begin
               cmd_in     = req_chan.cmd;
               now_in     = req_chan.now_ms;
               ch_in      = '0;
               phase_in   = rfb_pkg::PH_DIFF;
               reached_in = 1'b1;
               for (int k = 0; k < rfb_pkg::NUM_OUT_CH; k++) begin
                  duty_in[k] = '0;
               end
               if (req_chan.cmd) begin
                  // start: latch endpoints, blend at zero percent shows the start color (black in bounce mode)
                  for (int i = 0; i < NUM_CHANNELS; i++) begin
                     from_in[i] = bounce_mode_ff ? '0 : start_byte[i];
                     to_in[i]   = end_byte[i];
                  end
                  bouncing_in      = bounce_mode_ff;
                  limit_in         = bounce_mode_ff ? bounce_limit_ff : '0;
                  half_done_in     = '0;
                  begin_in         = req_chan.now_ms;
                  active_period_in = bounce_mode_ff ? {1'b0, period_ff[rfb_pkg::PERIOD_W-1:1]}
                                                    : period_ff;
                  pct_in           = '0;
                  state_in         = rfb_pkg::ST_BLEND;
               end else begin
                  div_req.start   = 1'b1;
                  div_req.elapsed = req_chan.now_ms - begin_ff;
                  div_req.period  = active_period_ff;
                  state_in        = rfb_pkg::ST_DIVIDE;
               end
            end
         end

         rfb_pkg::ST_DIVIDE: begin
            if (div_rsp.done) begin
               pct_in   = div_rsp.pct;
               state_in = rfb_pkg::ST_BLEND;
            end
         end

         rfb_pkg::ST_BLEND: begin
            case (phase_ff)
               rfb_pkg::PH_DIFF: begin
                  from_hold_in  = from_ff[0];
                  to_hold_in    = to_ff[0];
                  neg_in        = head_neg;
                  scale_hold_in = scale_sel;
                  prod1_in      = rfb_pkg::PROD1_W'(pct_ff) * rfb_pkg::PROD1_W'(head_mag);
                  // rotate both rings so the next channel comes to the head
                  for (int i = 0; i < NUM_CHANNELS; i++) begin
                     from_in[i] = from_ff[(i == NUM_CHANNELS - 1) ? 0 : i + 1];
                     to_in[i]   = to_ff[(i == NUM_CHANNELS - 1) ? 0 : i + 1];
                  end
                  phase_in = rfb_pkg::PH_DIV100;
               end
               rfb_pkg::PH_DIV100: begin
                  prod2_in = rfb_pkg::PROD2_W'(prod1_ff) * rfb_pkg::PROD2_W'(rfb_pkg::RECIP_100);
                  phase_in = rfb_pkg::PH_MIX;
               end
               rfb_pkg::PH_MIX: begin
                  if (mix_col != to_hold_ff) begin
                     reached_in = 1'b0;
                  end
                  x_in     = rfb_pkg::SCALED_W'(mix_col) * rfb_pkg::SCALED_W'(scale_hold_ff);
                  phase_in = rfb_pkg::PH_SCALE;
               end
               rfb_pkg::PH_SCALE: begin
                  for (int k = 0; k < rfb_pkg::NUM_OUT_CH; k++) begin
                     if (k < NUM_CHANNELS && ch_ff == CH_W'(k)) begin
                        duty_in[k] = duty_val;
                     end
                  end
                  phase_in = rfb_pkg::PH_DIFF;
                  if (ch_ff == LAST_CH) begin
                     state_in = rfb_pkg::ST_DONE;
                  end else begin
                     ch_in = ch_ff + CH_W'(1);
                  end
               end
               default: begin
                  phase_in = rfb_pkg::PH_DIFF;
               end
            endcase
         end

         rfb_pkg::ST_DONE: begin
            // result and state update go together once the output register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               for (int k = 0; k < rfb_pkg::NUM_OUT_CH; k++) begin
                  rsp_duty_in[k] = stop_now ? '0 : duty_ff[k];
               end
               rsp_over_in = over_next;
               rsp_stop_in = stop_now;
               if (bounce_hit) begin
                  if (limit_ff != '0) begin
                     half_done_in = half_next;
                  end
                  if (stop_now) begin
                     for (int i = 0; i < NUM_CHANNELS; i++) begin
                        from_in[i] = '0;
                        to_in[i]   = '0;
                     end
                     bouncing_in = 1'b0;
                  end else begin
                     for (int i = 0; i < NUM_CHANNELS; i++) begin
                        from_in[i] = to_ff[i];
                        to_in[i]   = from_ff[i];
                     end
                  end
                  begin_in = begin_next;
               end
               state_in = rfb_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = rfb_pkg::ST_IDLE;
         end
      endcase
   end

   // control, configuration and animation state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= rfb_pkg::ST_IDLE;
         phase_ff        <= rfb_pkg::PH_DIFF;
         rsp_valid_ff    <= 1'b0;
         start_color_ff  <= '0;
         end_color_ff    <= '0;
         period_ff       <= rfb_pkg::PERIOD_RST;
         bounce_mode_ff  <= 1'b0;
         bounce_limit_ff <= '0;
         scale_red_ff    <= rfb_pkg::SCALE_RED_RST;
         scale_green_ff  <= rfb_pkg::SCALE_GREEN_RST;
         scale_blue_ff   <= rfb_pkg::SCALE_BLUE_RST;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            from_ff[i] <= '0;
            to_ff[i]   <= '0;
         end
         bouncing_ff      <= 1'b0;
         begin_ff         <= '0;
         active_period_ff <= rfb_pkg::PERIOD_RST;
         half_done_ff     <= '0;
         limit_ff         <= '0;
      end else begin
         state_ff        <= state_in;
         phase_ff        <= phase_in;
         rsp_valid_ff    <= rsp_valid_in;
         start_color_ff  <= start_color_in;
         end_color_ff    <= end_color_in;
         period_ff       <= period_in;
         bounce_mode_ff  <= bounce_mode_in;
         bounce_limit_ff <= bounce_limit_in;
         scale_red_ff    <= scale_red_in;
         scale_green_ff  <= scale_green_in;
         scale_blue_ff   <= scale_blue_in;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            from_ff[i] <= from_in[i];
            to_ff[i]   <= to_in[i];
         end
         bouncing_ff      <= bouncing_in;
         begin_ff         <= begin_in;
         active_period_ff <= active_period_in;
         half_done_ff     <= half_done_in;
         limit_ff         <= limit_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ch_ff         <= ch_in;
      cmd_ff        <= cmd_in;
      now_ff        <= now_in;
      pct_ff        <= pct_in;
      reached_ff    <= reached_in;
      from_hold_ff  <= from_hold_in;
      to_hold_ff    <= to_hold_in;
      neg_ff        <= neg_in;
      scale_hold_ff <= scale_hold_in;
      prod1_ff      <= prod1_in;
      prod2_ff      <= prod2_in;
      x_ff          <= x_in;
      for (int k = 0; k < rfb_pkg::NUM_OUT_CH; k++) begin
         duty_ff[k]     <= duty_in[k];
         rsp_duty_ff[k] <= rsp_duty_in[k];
      end
      rsp_over_ff <= rsp_over_in;
      rsp_stop_ff <= rsp_stop_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.duty_red    = rsp_duty_ff[0];
   assign rsp_chan.duty_green  = rsp_duty_ff[1];
   assign rsp_chan.duty_blue   = rsp_duty_ff[2];
   assign rsp_chan.period_over = rsp_over_ff;
   assign rsp_chan.stopped     = rsp_stop_ff;

   // checks
   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (div_rsp.pct <= rfb_pkg::PCT_FULL))
      else $error("percent from divider above 100");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != rfb_pkg::ST_IDLE))
      else $error("request accepted but engine stayed idle");

   a_ch_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rfb_pkg::ST_BLEND) |-> (ch_ff <= LAST_CH))
      else $error("channel counter past last channel");

   a_stop_dark: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stop_ff) |-> (rsp_duty_ff[0] == '0 && rsp_duty_ff[1] == '0
                                         && rsp_duty_ff[2] == '0))
      else $error("stopped result with lights on");

   a_stop_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rfb_pkg::ST_DONE && rsp_free && stop_now)
      |=> (!bouncing_ff && begin_ff == '0))
      else $error("bounce limit reached but bounce state not cleared");

endmodule

FILE: dv/testbench.sv
// self-checking testbench of the rgb fade and bounce engine, directed and random requests
module testbench;
   import rfb_pkg::*;

   localparam int CHANNELS      = NUM_OUT_CH;
   localparam int RESET_CYCLES  = 12;
   localparam int MAX_GAP       = 14;
   // worst quiet stretch is a sender gap, one render and a receiver stall, far below this
   localparam int QUIET_LIMIT   = 3000;
   // drain tail: the length of one render plus a margin
   localparam int TAIL_CYCLES   = 4 * CHANNELS + 11 + 20;
   localparam int MAX_REPORTS   = 10;
   localparam int RANDOM_PHASES = 19;
   localparam int PHASE_ITEMS   = 100;

   localparam logic CMD_RENDER = 1'b0;
   localparam logic CMD_START  = 1'b1;

   // one result as the engine returns it
   typedef struct packed {
      logic [DUTY_W-1:0] duty_red;
      logic [DUTY_W-1:0] duty_green;
      logic [DUTY_W-1:0] duty_blue;
      logic              period_over;
      logic              stopped;
   } duty_word_t;

   logic clock = 1'b0;
   logic reset;

   rfb_req_if req_chan ();
   rfb_rsp_if rsp_chan ();
   rfb_csr_if csr_chan ();

   rgb_fade_bounce_engine_top #(
      .NUM_CHANNELS(CHANNELS)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_chan(csr_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // register copies as written over the csr channel
   logic [COLOR_W-1:0]  reg_start_color;
   logic [COLOR_W-1:0]  reg_end_color;
   logic [PERIOD_W-1:0] reg_period;
   logic                reg_bounce;
   logic [LIMIT_W-1:0]  reg_limit;
   logic [SCALE_W-1:0]  reg_scale [CHANNELS];

   // animation state of the predictor
   logic [BYTE_W-1:0]   fade_from [CHANNELS];
   logic [BYTE_W-1:0]   fade_to   [CHANNELS];
   logic                bounce_on;
   logic [TIME_W-1:0]   anchor_ms;
   logic [PERIOD_W-1:0] run_period;
   logic [HALF_W-1:0]   half_count;
   logic [LIMIT_W-1:0]  stop_after;

   // duties still owed by the engine, oldest first
   duty_word_t expected_duties [$];

   // pacing: steady means no idle cycles on that side for the current phase
   bit req_steady = 1'b0;
   bit rsp_steady = 1'b0;

   int unsigned mismatches   = 0;
   int unsigned requests     = 0;
   int unsigned starts       = 0;
   int unsigned results_seen = 0;
   int unsigned csr_writes   = 0;
   int unsigned limit_stops  = 0;

   // ---------------------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------------------

   function automatic logic [BYTE_W-1:0] color_byte(input logic [COLOR_W-1:0] rgb,
                                                    input int ch);
      return rgb[BYTE_W*(CHANNELS-1-ch) +: BYTE_W];
   endfunction

   // normalise by scale/255 and saturate
   function automatic logic [DUTY_W-1:0] duty_of(input logic [BYTE_W-1:0] level,
                                                 input logic [SCALE_W-1:0] gain);
      int unsigned q;
      q = (int'(level) * int'(gain)) / 255;
      return (q > 255) ? DUTY_MAX : q[DUTY_W-1:0];
   endfunction

   task automatic reset_shadow();
      reg_start_color = '0;
      reg_end_color   = '0;
      reg_period      = PERIOD_RST;
      reg_bounce      = 1'b0;
      reg_limit       = '0;
      reg_scale[0]    = SCALE_RED_RST;
      reg_scale[1]    = SCALE_GREEN_RST;
      reg_scale[2]    = SCALE_BLUE_RST;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         fade_from[ch] = '0;
         fade_to[ch]   = '0;
      end
      bounce_on  = 1'b0;
      anchor_ms  = '0;
      run_period = PERIOD_RST;
      half_count = '0;
      stop_after = '0;
   endtask

   // register values are kept masked to their widths
   task automatic apply_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_START_COLOR:  reg_start_color = value[COLOR_W-1:0];
         CSR_END_COLOR:    reg_end_color   = value[COLOR_W-1:0];
         CSR_PERIOD_MS:    reg_period      = value[PERIOD_W-1:0];
         CSR_BOUNCE_MODE:  reg_bounce      = value[0];
         CSR_BOUNCE_LIMIT: reg_limit       = value[LIMIT_W-1:0];
         CSR_SCALE_RED:    reg_scale[0]    = value[SCALE_W-1:0];
         CSR_SCALE_GREEN:  reg_scale[1]    = value[SCALE_W-1:0];
         CSR_SCALE_BLUE:   reg_scale[2]    = value[SCALE_W-1:0];
         default: ;
      endcase
   endtask

   // advance the animation by one request and queue the duties it should produce
   task automatic predict_result(input logic cmd, input logic [TIME_W-1:0] now);
      logic [BYTE_W-1:0] level [CHANNELS];
      logic [BYTE_W-1:0] held;
      logic [TIME_W-1:0] since;
      longint unsigned   pct;
      int                step_size;
      int                nudge;
      logic              at_target;
      logic              lights_out;
      duty_word_t        want;

      want       = '0;
      at_target  = 1'b0;
      lights_out = 1'b0;
      if (cmd == CMD_START) begin
         // bounce mode starts from black over half the period
         for (int ch = 0; ch < CHANNELS; ch++) begin
            fade_from[ch] = reg_bounce ? '0 : color_byte(reg_start_color, ch);
            fade_to[ch]   = color_byte(reg_end_color, ch);
            level[ch]     = fade_from[ch];
         end
         bounce_on  = reg_bounce;
         stop_after = reg_bounce ? reg_limit : '0;
         half_count = '0;
         anchor_ms  = now;
         run_period = reg_bounce ? (reg_period >> 1) : reg_period;
         starts++;
      end else begin
         since = now - anchor_ms;
         // a zero period counts as fully done, no divide
         if (run_period == 0) begin
            pct = 100;
         end else begin
            pct = (64'(since) * 64'd100) / 64'(run_period);
            if (pct > 100) begin
               pct = 100;
            end
         end
         at_target = 1'b1;
         for (int ch = 0; ch < CHANNELS; ch++) begin
            step_size = int'(fade_to[ch]) - int'(fade_from[ch]);
            nudge     = (int'(pct) * step_size) / 100;   // truncates toward zero
            level[ch] = BYTE_W'(int'(fade_from[ch]) + nudge);
            if (level[ch] != fade_to[ch]) begin
               at_target = 1'b0;
            end
         end
      end

      want.duty_red   = duty_of(level[0], reg_scale[0]);
      want.duty_green = duty_of(level[1], reg_scale[1]);
      want.duty_blue  = duty_of(level[2], reg_scale[2]);

      // bounce turnaround, and the stop once the limit of half-cycles is used up
      if (cmd == CMD_RENDER && bounce_on && at_target) begin
         if (stop_after != 0) begin
            half_count = half_count + 1'b1;
            lights_out = ((half_count >> 1) == stop_after);
         end
         if (lights_out) begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
               fade_from[ch] = '0;
               fade_to[ch]   = '0;
            end
            bounce_on       = 1'b0;
            anchor_ms       = '0;
            want.duty_red   = '0;
            want.duty_green = '0;
            want.duty_blue  = '0;
            limit_stops++;
         end else begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
               held          = fade_from[ch];
               fade_from[ch] = fade_to[ch];
               fade_to[ch]   = held;
            end
            anchor_ms = now;
         end
      end

      // judged on the state after this request
      since            = now - anchor_ms;
      want.period_over = (since > {1'b0, run_period});
      want.stopped     = lights_out;
      expected_duties.push_back(want);
   endtask

   // ---------------------------------------------------------------------------------
   // monitors: prediction on accepted requests and writes, checking on results
   // ---------------------------------------------------------------------------------

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_chan.valid && csr_chan.ready) begin
            apply_register(csr_index_type'(csr_chan.index), csr_chan.data);
            csr_writes++;
         end
         if (req_chan.valid && req_chan.ready) begin
            predict_result(req_chan.cmd, req_chan.now_ms);
            requests++;
         end
      end
   end

   always @(posedge clock) begin : check_results
      duty_word_t got;
      duty_word_t want;

      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = {rsp_chan.duty_red, rsp_chan.duty_green, rsp_chan.duty_blue,
                rsp_chan.period_over, rsp_chan.stopped};
         results_seen++;
         if (expected_duties.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("unexpected result: rgb %0d %0d %0d over %0b stopped %0b",
                        got.duty_red, got.duty_green, got.duty_blue,
                        got.period_over, got.stopped);
            end
         end else begin
            want = expected_duties.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("result %0d: expected rgb %0d %0d %0d over %0b stopped %0b",
                           results_seen, want.duty_red, want.duty_green, want.duty_blue,
                           want.period_over, want.stopped);
                  $display("result %0d: actual   rgb %0d %0d %0d over %0b stopped %0b",
                           results_seen, got.duty_red, got.duty_green, got.duty_blue,
                           got.period_over, got.stopped);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // channel drivers: inputs change on the falling edge
   // ---------------------------------------------------------------------------------

   // result side: a fresh stall before each result, none in steady phases
   initial begin : result_pacing
      int unsigned stall;

      rsp_chan.ready = 1'b0;
      forever begin
         stall = rsp_steady ? 0 : $urandom_range(0, MAX_GAP);
         @(negedge clock);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_chan.valid && rsp_chan.ready)) @(posedge clock);
      end
   end

   // valid stays high after acceptance so back-to-back requests need not drop and raise it again
   task automatic send_request(input logic cmd, input logic [TIME_W-1:0] now);
      int unsigned gap;

      gap = req_steady ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.cmd    <= cmd;
      req_chan.now_ms <= now;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // drop the request valid and wait until every owed result is back
   task automatic wait_idle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (expected_duties.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------------

   // renders straight out of reset: black, 1000 ms period, begin time zero
   task automatic test_reset_state();
      send_request(CMD_RENDER, 32'd0);
      send_request(CMD_RENDER, 32'd1000);
      send_request(CMD_RENDER, 32'd1001);
      send_request(CMD_RENDER, 32'hFFFF_FFFF);
   endtask

   // white to black over 2 ms across the time wrap, upper data bits must be ignored
   task automatic test_one_way_fade();
      wait_idle();
      write_register(CSR_START_COLOR,  31'h7FFF_FFFF);
      write_register(CSR_END_COLOR,    31'h7F00_0000);
      write_register(CSR_PERIOD_MS,    31'd2);
      write_register(CSR_BOUNCE_MODE,  31'h7FFF_FFFE);
      write_register(CSR_BOUNCE_LIMIT, 31'h7FFF_FF00);
      write_register(CSR_SCALE_RED,    31'h7FFF_FFFF);
      write_register(CSR_SCALE_GREEN,  31'd0);
      write_register(CSR_SCALE_BLUE,   31'd255);
      send_request(CMD_START,  32'hFFFF_FFFF);
      send_request(CMD_RENDER, 32'd0);
      send_request(CMD_RENDER, 32'd1);
      send_request(CMD_RENDER, 32'd2);
      send_request(CMD_RENDER, 32'hFFFF_FFFE);
   endtask

   // longest period, elapsed at half, right at and past the period
   task automatic test_period_extremes();
      wait_idle();
      write_register(CSR_START_COLOR, 31'd0);
      write_register(CSR_END_COLOR,   31'h00FF_FFFF);
      write_register(CSR_PERIOD_MS,   31'h7FFF_FFFF);
      write_register(CSR_SCALE_GREEN, 31'd256);
      send_request(CMD_START,  32'd0);
      send_request(CMD_RENDER, 32'h7FFF_FFFF);
      send_request(CMD_RENDER, 32'h8000_0000);
      send_request(CMD_RENDER, 32'h4000_0000);
   endtask

   // zero period one-way, then a bounce whose halved period is zero with no limit
   task automatic test_zero_period();
      wait_idle();
      write_register(CSR_PERIOD_MS, 31'd0);
      send_request(CMD_START,  32'd5);
      send_request(CMD_RENDER, 32'd5);
      wait_idle();
      write_register(CSR_PERIOD_MS,    31'd1);
      write_register(CSR_BOUNCE_MODE,  31'd1);
      write_register(CSR_BOUNCE_LIMIT, 31'd0);
      send_request(CMD_START,  32'd7);
      send_request(CMD_RENDER, 32'd7);
      send_request(CMD_RENDER, 32'd7);
   endtask

   // limit of one bounce: turn at the peak, lights out back at black, then a one-way start
   task automatic test_bounce_stop();
      wait_idle();
      write_register(CSR_PERIOD_MS,    31'd20);
      write_register(CSR_END_COLOR,    31'h0080_FF01);
      write_register(CSR_BOUNCE_LIMIT, 31'd1);
      write_register(CSR_SCALE_RED,    31'd256);
      send_request(CMD_START,  32'd100);
      send_request(CMD_RENDER, 32'd105);
      send_request(CMD_RENDER, 32'd110);
      send_request(CMD_RENDER, 32'd115);
      send_request(CMD_RENDER, 32'd120);
      send_request(CMD_RENDER, 32'd130);
      wait_idle();
      write_register(CSR_BOUNCE_MODE, 31'd0);
      send_request(CMD_START, 32'd200);
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_color();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return 31'h00FF_FFFF;
         2:       return CSR_DATA_W'($urandom);
         default: return CSR_DATA_W'($urandom_range(0, 24'hFF_FFFF));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_scale();
      case ($urandom_range(0, 7))
         0:       return 31'd0;
         1:       return 31'd255;
         2:       return 31'd256;
         3:       return 31'd511;
         4:       return CSR_DATA_W'($urandom);
         default: return CSR_DATA_W'($urandom_range(0, 300));
      endcase
   endfunction

   // the first two phases take the high and the low extremes, the rest are drawn
   task automatic randomize_registers(input int phase);
      logic [CSR_DATA_W-1:0] value;

      if (phase == 0) begin
         write_register(CSR_START_COLOR,  31'h00FF_FFFF);
         write_register(CSR_END_COLOR,    31'd0);
         write_register(CSR_PERIOD_MS,    31'h7FFF_FFFF);
         write_register(CSR_BOUNCE_MODE,  31'd1);
         write_register(CSR_BOUNCE_LIMIT, 31'd255);
         write_register(CSR_SCALE_RED,    31'd511);
         write_register(CSR_SCALE_GREEN,  31'd511);
         write_register(CSR_SCALE_BLUE,   31'd511);
      end else if (phase == 1) begin
         write_register(CSR_START_COLOR,  31'd0);
         write_register(CSR_END_COLOR,    31'h00FF_FFFF);
         write_register(CSR_PERIOD_MS,    31'd2);
         write_register(CSR_BOUNCE_MODE,  31'd1);
         write_register(CSR_BOUNCE_LIMIT, 31'd1);
         write_register(CSR_SCALE_RED,    31'd0);
         write_register(CSR_SCALE_GREEN,  31'd0);
         write_register(CSR_SCALE_BLUE,   31'd0);
      end else begin
         write_register(CSR_START_COLOR, pick_color());
         write_register(CSR_END_COLOR,   pick_color());
         // short periods dominate so that bounces turn and limits run out
         case ($urandom_range(0, 9))
            0:       value = $urandom_range(0, 1);
            1:       value = 31'h7FFF_FFFF;
            2:       value = CSR_DATA_W'($urandom);
            3:       value = $urandom_range(2, 100000);
            default: value = $urandom_range(2, 40);
         endcase
         write_register(CSR_PERIOD_MS, value);
         value    = CSR_DATA_W'($urandom);
         value[0] = ($urandom_range(0, 3) != 0);
         write_register(CSR_BOUNCE_MODE, value);
         case ($urandom_range(0, 7))
            0:       value = 31'd0;
            1:       value = 31'd255;
            2:       value = CSR_DATA_W'($urandom);
            default: value = $urandom_range(1, 6);
         endcase
         write_register(CSR_BOUNCE_LIMIT, value);
         write_register(CSR_SCALE_RED,    pick_scale());
         write_register(CSR_SCALE_GREEN,  pick_scale());
         write_register(CSR_SCALE_BLUE,   pick_scale());
      end
   endtask

   // one animation: a start, then renders with rising time and some noise and restarts
   task automatic run_fade_sequence(input int unsigned count);
      logic [TIME_W-1:0] t;
      int unsigned       roll;
      int unsigned       span;

      t = $urandom;
      send_request(CMD_START, t);
      for (int unsigned k = 1; k < count; k++) begin
         roll = $urandom_range(0, 99);
         if (roll < 4) begin
            t = t + $urandom_range(0, 3);
            send_request(CMD_START, t);
         end else if (roll < 12) begin
            send_request(CMD_RENDER, $urandom);
         end else begin
            if (run_period == 0) begin
               span = 3;
            end else if (run_period < 100000) begin
               span = run_period / 2 + 1;
            end else begin
               span = 32'hFFFF_FFFF;
            end
            // a share of steps moves on by exactly one whole period
            if (roll < 18) begin
               t = t + run_period;
            end else begin
               t = t + $urandom_range(0, span);
            end
            send_request(CMD_RENDER, t);
         end
      end
   endtask

   task automatic test_random_phases();
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_idle();
         randomize_registers(p);
         req_steady = (p % 5 == 1) || ($urandom_range(0, 5) == 0);
         rsp_steady = (p % 5 == 2) || ($urandom_range(0, 5) == 0);
         run_fade_sequence(PHASE_ITEMS);
      end
      req_steady = 1'b0;
      rsp_steady = 1'b0;
   endtask

   // ---------------------------------------------------------------------------------
   // watchdog: ends the run after a long stretch with no handshake at all
   // ---------------------------------------------------------------------------------

   initial begin : watchdog
      int unsigned quiet;

      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
             (csr_chan.valid && csr_chan.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("no handshake for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, expected_duties.size());
      $display("rgb_fade_bounce_engine_top: mismatch");
      $finish;
   end

   // ---------------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------------

   initial begin
      reset           = 1'b1;
      req_chan.valid  = 1'b0;
      req_chan.cmd    = CMD_RENDER;
      req_chan.now_ms = '0;
      csr_chan.valid  = 1'b0;
      csr_chan.index  = CSR_START_COLOR;
      csr_chan.data   = '0;
      reset_shadow();

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_one_way_fade();
      test_period_extremes();
      test_zero_period();
      test_bounce_stop();
      test_random_phases();

      // let everything drain, then give late or extra results a chance to show up
      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d requests sent (%0d starts), %0d register writes, %0d results compared",
               requests, starts, csr_writes, results_seen);
      $display("%0d bounce limit stops, %0d mismatches, %0d results never returned",
               limit_stops, mismatches, expected_duties.size());
      if (mismatches == 0 && expected_duties.size() == 0) begin
         $display("rgb_fade_bounce_engine_top: match");
      end else begin
         $display("rgb_fade_bounce_engine_top: mismatch");
      end
      $finish;
   end

endmodule

FILE: rgb_fade_bounce_engine_top.f
src/rfb_pkg.sv
src/rfb_channels.sv
src/rfb_pct_divider.sv
src/rgb_fade_bounce_engine_top.sv
dv/testbench.sv
